### rtl/core/dcpt_pkg.sv
`default_nettype none

package dcpt_pkg;

  localparam int unsigned SecW = 32;
  localparam int unsigned MicW = 20;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [MicW:0]   MicrosPerSec = 21'd1000000;
  localparam logic [MicW-1:0] MicrosMax    = 20'd999999;
  localparam logic [MicW-1:0] MinMicros    = 20'd2;
  localparam logic [MicW-1:0] ResetMicros  = 20'd20000;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_EXPIRY = 2'd1,
    KIND_STOP   = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INTERVAL_SECS   = 2'd0,
    CFG_INTERVAL_MICROS = 2'd1,
    CFG_CORR_ENABLE     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [SecW-1:0] s;
    logic [MicW-1:0] u;
  } tval_t;

  typedef struct packed {
    tval_t asked;
    logic  corr_en;
  } cfg_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [SecW-1:0] now_secs;
    logic [MicW-1:0] now_micros;
  } in_item_t;

  typedef struct packed {
    tval_t           prev;
    tval_t           corr;
    logic [SecW-1:0] count;
    tval_t           acc;
    logic            started;
  } st_t;

  typedef struct packed {
    logic            delay_issued;
    logic [SecW-1:0] delay_secs;
    logic [MicW-1:0] delay_micros;
    logic            client_notify;
    logic [SecW-1:0] event_total;
    logic [SecW-1:0] total_secs;
    logic [MicW-1:0] total_micros;
    logic            running;
  } out_item_t;

  function automatic logic [MicW-1:0] sat_micros(logic [MicW-1:0] v);
    return (v > MicrosMax) ? MicrosMax : v;
  endfunction

  function automatic tval_t t_add(tval_t a, tval_t b);
    logic [MicW:0] u_w;
    logic          carry;
    tval_t         r;
    u_w   = {1'b0, a.u} + {1'b0, b.u};
    carry = 1'b0;
    if (u_w >= MicrosPerSec) begin
      u_w   = u_w - MicrosPerSec;
      carry = 1'b1;
    end
    r.u = u_w[MicW-1:0];
    r.s = a.s + b.s + {{(SecW-1){1'b0}}, carry};
    return r;
  endfunction

  function automatic tval_t t_sub(tval_t a, tval_t b);
    logic [MicW:0] u_w;
    logic          borrow;
    tval_t         r;
    if (a.u < b.u) begin
      u_w    = {1'b0, a.u} + MicrosPerSec - {1'b0, b.u};
      borrow = 1'b1;
    end else begin
      u_w    = {1'b0, a.u} - {1'b0, b.u};
      borrow = 1'b0;
    end
    r.u = u_w[MicW-1:0];
    r.s = a.s - b.s - {{(SecW-1){1'b0}}, borrow};
    return r;
  endfunction

  function automatic logic t_lt(tval_t a, tval_t b);
    return (a.s < b.s) || ((a.s == b.s) && (a.u < b.u));
  endfunction

  function automatic tval_t t_floor(tval_t t);
    tval_t r;
    r = t;
    if ((t.s == '0) && (t.u < MinMicros)) begin
      r.u = MinMicros;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/dcpt_in_if.sv
`default_nettype none

interface dcpt_in_if;
  import dcpt_pkg::*;

  logic            valid;
  logic            ready;
  logic [1:0]      kind;
  logic [SecW-1:0] now_secs;
  logic [MicW-1:0] now_micros;

  modport source (output valid, kind, now_secs, now_micros, input ready);
  modport sink   (input valid, kind, now_secs, now_micros, output ready);
endinterface

`default_nettype wire

### rtl/core/dcpt_out_if.sv
`default_nettype none

interface dcpt_out_if;
  import dcpt_pkg::*;

  logic            valid;
  logic            ready;
  logic            delay_issued;
  logic [SecW-1:0] delay_secs;
  logic [MicW-1:0] delay_micros;
  logic            client_notify;
  logic [SecW-1:0] event_total;
  logic [SecW-1:0] total_secs;
  logic [MicW-1:0] total_micros;
  logic            running;

  modport source (output valid, delay_issued, delay_secs, delay_micros, client_notify,
                  event_total, total_secs, total_micros, running, input ready);
  modport sink   (input valid, delay_issued, delay_secs, delay_micros, client_notify,
                  event_total, total_secs, total_micros, running, output ready);
endinterface

`default_nettype wire

### rtl/core/dcpt_cfg_regs.sv
`default_nettype none

module dcpt_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [dcpt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [dcpt_pkg::CfgDataW-1:0]  cfg_data_i,
  output dcpt_pkg::cfg_t                      cfg_o
);
  import dcpt_pkg::*;

  logic [SecW-1:0] isecs_q;
  logic [MicW-1:0] imicros_q;
  logic            corr_en_q;
  tval_t           asked;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      isecs_q   <= '0;
      imicros_q <= ResetMicros;
      corr_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_INTERVAL_SECS:   isecs_q   <= cfg_data_i[SecW-1:0];
        CFG_INTERVAL_MICROS: imicros_q <= cfg_data_i[MicW-1:0];
        CFG_CORR_ENABLE:     corr_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // requested period, micros saturated, whole value floored to the minimum
  always_comb begin
    asked.s = isecs_q;
    asked.u = sat_micros(imicros_q);
    cfg_o.asked   = t_floor(asked);
    cfg_o.corr_en = corr_en_q;
  end

endmodule

`default_nettype wire

### rtl/core/dcpt_step.sv
`default_nettype none

module dcpt_step (
  input  wire dcpt_pkg::cfg_t      cfg_i,
  input  wire dcpt_pkg::st_t       st_i,
  input  wire dcpt_pkg::in_item_t  item_i,
  output dcpt_pkg::st_t            st_o,
  output dcpt_pkg::out_item_t      res_o
);
  import dcpt_pkg::*;

  tval_t now;
  tval_t elapsed;
  tval_t excess;
  tval_t shortfall;
  tval_t shrunk;
  tval_t grown;
  tval_t floor_val;
  logic  late;
  logic  early;
  logic  issued;
  logic  notify;

  always_comb begin
    now.s = item_i.now_secs;
    now.u = sat_micros(item_i.now_micros);

    elapsed   = t_sub(now, st_i.prev);
    late      = t_lt(cfg_i.asked, elapsed);
    early     = t_lt(elapsed, cfg_i.asked);
    excess    = t_sub(elapsed, cfg_i.asked);
    shortfall = t_sub(cfg_i.asked, elapsed);
    shrunk    = t_floor(t_sub(st_i.corr, excess));
    grown     = t_add(st_i.corr, shortfall);
    floor_val.s = '0;
    floor_val.u = MinMicros;

    st_o   = st_i;
    issued = 1'b0;
    notify = 1'b0;

    case (kind_e'(item_i.kind))
      KIND_START: begin
        if (!st_i.started) begin
          st_o.prev    = now;
          st_o.corr    = cfg_i.asked;
          st_o.count   = '0;
          st_o.acc     = '0;
          st_o.started = 1'b1;
          issued       = 1'b1;
        end
      end
      KIND_EXPIRY: begin
        st_o.count = st_i.count + SecW'(1);
        if (cfg_i.corr_en) begin
          if (late) begin
            // late by the whole delay or more drops to the floor
            st_o.corr = t_lt(excess, st_i.corr) ? shrunk : floor_val;
          end else if (early) begin
            st_o.corr = grown;
          end
          st_o.prev = now;
        end
        if (st_i.started) begin
          st_o.acc = t_add(st_i.acc, cfg_i.asked);
          issued   = 1'b1;
          notify   = 1'b1;
        end
      end
      KIND_STOP: begin
        st_o.started = 1'b0;
      end
      default: ;
    endcase

    res_o.delay_issued  = issued;
    res_o.delay_secs    = st_o.corr.s;
    res_o.delay_micros  = st_o.corr.u;
    res_o.client_notify = notify;
    res_o.event_total   = st_o.count;
    res_o.total_secs    = st_o.acc.s;
    res_o.total_micros  = st_o.acc.u;
    res_o.running       = st_o.started;
  end

endmodule

`default_nettype wire

### rtl/core/drift_corrected_periodic_timer_unit.sv
`default_nettype none

// channel  dir  handshake     carries
// evt_i    in   valid/ready   kind, now_secs, now_micros
// res_o    out  valid/ready   delay, notify, event total, nominal total, running
// cfg      in   cfg_we_i      cfg_idx_i selects register, cfg_data_i value
//
// one word in per cycle while the result register is not stalled; a word passes the input reg, then the result reg
// timer state moves as a word passes from the input register to the result register
// a stalled result register holds the input register; evt_i stays ready while it is free
// reset: all timer state cleared, interval 0 s 20000 us, correction off

module drift_corrected_periodic_timer_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  dcpt_in_if.sink                            evt_i,
  dcpt_out_if.source                         res_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [dcpt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [dcpt_pkg::CfgDataW-1:0] cfg_data_i
);
  import dcpt_pkg::*;

  cfg_t      cfg;
  st_t       st_q, st_d;
  in_item_t  in_q;
  logic      in_vld_q, in_vld_d;
  out_item_t out_q, out_d;
  logic      out_vld_q, out_vld_d;
  logic      adv;
  logic      evt_acc;

  dcpt_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  dcpt_step u_step (
    .cfg_i  (cfg),
    .st_i   (st_q),
    .item_i (in_q),
    .st_o   (st_d),
    .res_o  (out_d)
  );

  assign adv         = in_vld_q && (!out_vld_q || res_o.ready);
  assign evt_i.ready = !in_vld_q || adv;
  assign evt_acc     = evt_i.valid && evt_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (evt_acc) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (adv) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_acc) begin
      in_q.kind       <= evt_i.kind;
      in_q.now_secs   <= evt_i.now_secs;
      in_q.now_micros <= evt_i.now_micros;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.delay_issued  = out_q.delay_issued;
  assign res_o.delay_secs    = out_q.delay_secs;
  assign res_o.delay_micros  = out_q.delay_micros;
  assign res_o.client_notify = out_q.client_notify;
  assign res_o.event_total   = out_q.event_total;
  assign res_o.total_secs    = out_q.total_secs;
  assign res_o.total_micros  = out_q.total_micros;
  assign res_o.running       = out_q.running;

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("result register not filled after a word moved on");

  a_running_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (res_o.running == st_q.started))
    else $error("shown running flag differs from timer state");

  a_notify_needs_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_o.client_notify) |-> res_o.delay_issued)
    else $error("client notified without a delay issued");

  a_held_word_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !adv) |=> in_vld_q)
    else $error("waiting input word dropped");

endmodule

`default_nettype wire

### bench/timer_result_check.sv
`default_nettype none

module timer_result_check (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  dcpt_in_if                                 evt,
  dcpt_out_if                                res,
  input  wire logic                          cfg_we_i,
  input  wire logic [dcpt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [dcpt_pkg::CfgDataW-1:0] cfg_data_i,
  output int unsigned                        fails_o,
  output int unsigned                        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import dcpt_pkg::*;

  st_t             timer;
  logic [SecW-1:0] period_secs;
  logic [MicW-1:0] period_micros;
  logic            corr_on;
  out_item_t       report_q[$];

  function automatic logic [MicW-1:0] clamp_us(logic [MicW-1:0] v);
    return (v > MicrosMax) ? MicrosMax : v;
  endfunction

  function automatic tval_t at_least_min(tval_t t);
    tval_t r;
    r = t;
    if (r.s == '0 && r.u < MinMicros) r.u = MinMicros;
    return r;
  endfunction

  function automatic tval_t tv_plus(tval_t a, tval_t b);
    logic [MicW:0] w;
    tval_t         r;
    w   = {1'b0, a.u} + {1'b0, b.u};
    r.s = a.s + b.s;
    if (w >= MicrosPerSec) begin
      w   = w - MicrosPerSec;
      r.s = r.s + 1'b1;
    end
    r.u = w[MicW-1:0];
    return r;
  endfunction

  function automatic tval_t tv_minus(tval_t a, tval_t b);
    logic [MicW:0] w;
    tval_t         r;
    if (a.u < b.u) begin
      w   = {1'b0, a.u} + MicrosPerSec - {1'b0, b.u};
      r.s = a.s - b.s - 1'b1;
    end else begin
      w   = {1'b0, a.u} - {1'b0, b.u};
      r.s = a.s - b.s;
    end
    r.u = w[MicW-1:0];
    return r;
  endfunction

  function automatic bit tv_before(tval_t a, tval_t b);
    return (a.s < b.s) || (a.s == b.s && a.u < b.u);
  endfunction

  // advances the timer by one event and returns the word it should report
  function automatic out_item_t next_report(in_item_t ev);
    tval_t     now_t;
    tval_t     asked;
    tval_t     corr;
    tval_t     elapsed;
    tval_t     excess;
    out_item_t r;
    now_t = '{s: ev.now_secs, u: clamp_us(ev.now_micros)};
    asked = at_least_min('{s: period_secs, u: clamp_us(period_micros)});
    corr  = '{s: timer.corr.s, u: clamp_us(timer.corr.u)};
    r     = '0;
    case (ev.kind)
      KIND_START: begin
        if (!timer.started) begin
          timer.prev    = now_t;
          corr          = asked;
          timer.count   = '0;
          timer.acc     = '0;
          timer.started = 1'b1;
          r.delay_issued = 1'b1;
        end
      end
      KIND_EXPIRY: begin
        timer.count = timer.count + 1'b1;
        if (corr_on) begin
          elapsed = tv_minus(now_t, timer.prev);
          if (tv_before(asked, elapsed)) begin
            excess = tv_minus(elapsed, asked);
            if (tv_before(excess, corr)) corr = at_least_min(tv_minus(corr, excess));
            else corr = '{s: '0, u: MinMicros};
          end else if (tv_before(elapsed, asked)) begin
            corr = tv_plus(corr, tv_minus(asked, elapsed));
          end
          timer.prev = now_t;
        end
        if (timer.started) begin
          timer.acc       = tv_plus(timer.acc, asked);
          r.delay_issued  = 1'b1;
          r.client_notify = 1'b1;
        end
      end
      KIND_STOP: timer.started = 1'b0;
      default: ;
    endcase
    timer.corr     = corr;
    r.delay_secs   = corr.s;
    r.delay_micros = corr.u;
    r.event_total  = timer.count;
    r.total_secs   = timer.acc.s;
    r.total_micros = timer.acc.u;
    r.running      = timer.started;
    return r;
  endfunction

  function automatic void check_field(string name, logic [SecW-1:0] want, logic [SecW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    in_item_t  ev;
    out_item_t want;
    if (!rst_ni) begin
      timer         = '0;
      period_secs   = '0;
      period_micros = ResetMicros;
      corr_on       = 1'b0;
      report_q.delete();
      fails_o       = 0;
      pending_o     = 0;
    end else begin
      if (evt.valid && evt.ready) begin
        ev.kind       = evt.kind;
        ev.now_secs   = evt.now_secs;
        ev.now_micros = evt.now_micros;
        report_q.push_back(next_report(ev));
      end
      if (res.valid && res.ready) begin
        if (report_q.size() == 0) begin
          $error("result word arrived with nothing outstanding");
          fails_o++;
        end else begin
          want = report_q.pop_front();
          check_field("delay_issued", want.delay_issued, res.delay_issued);
          check_field("delay_secs", want.delay_secs, res.delay_secs);
          check_field("delay_micros", want.delay_micros, res.delay_micros);
          check_field("client_notify", want.client_notify, res.client_notify);
          check_field("event_total", want.event_total, res.event_total);
          check_field("total_secs", want.total_secs, res.total_secs);
          check_field("total_micros", want.total_micros, res.total_micros);
          check_field("running", want.running, res.running);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_INTERVAL_SECS:   period_secs   = cfg_data_i[SecW-1:0];
          CFG_INTERVAL_MICROS: period_micros = cfg_data_i[MicW-1:0];
          CFG_CORR_ENABLE:     corr_on       = cfg_data_i[0];
          default: ;
        endcase
      end
      pending_o = report_q.size();
    end
  end

endmodule

`default_nettype wire

### bench/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dcpt_pkg::*;

  localparam int unsigned   StallLimit = 5000;
  localparam int unsigned   Sessions   = 44;
  localparam logic [1:0]    KindUnused = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int unsigned     fails;
  int unsigned     pending;
  int unsigned     gap_pct   = 0;
  int unsigned     stall_pct = 0;
  int unsigned     idle_cycles = 0;
  int unsigned     kinds_sent[4];
  int unsigned     settings_used = 0;
  longint unsigned period_us;
  logic [SecW-1:0] wall_secs;
  logic [MicW-1:0] wall_us;

  dcpt_in_if  evt ();
  dcpt_out_if res ();

  drift_corrected_periodic_timer_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .evt_i      (evt),
    .res_o      (res),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  timer_result_check result_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .evt        (evt),
    .res        (res),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fails_o    (fails),
    .pending_o  (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    res.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((evt.valid && evt.ready) || (res.valid && res.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_event(input logic [1:0] kind, input logic [SecW-1:0] secs,
                            input logic [MicW-1:0] us);
    if ($urandom_range(99) < gap_pct) begin
      evt.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    evt.valid      <= 1'b1;
    evt.kind       <= kind;
    evt.now_secs   <= secs;
    evt.now_micros <= us;
    do @(posedge clk_i); while (!evt.ready);
    kinds_sent[kind]++;
  endtask

  // registers may only change once every outstanding word is back
  task automatic settle();
    evt.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_settings(input logic [SecW-1:0] secs, input logic [MicW-1:0] us,
                                input logic en);
    logic [CfgDataW-2:0] junk;
    junk = $urandom();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_INTERVAL_SECS;
    cfg_data_i <= secs;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_INTERVAL_MICROS;
    cfg_data_i <= CfgDataW'(us);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_CORR_ENABLE;
    cfg_data_i <= {junk, en};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    period_us = longint'(secs) * 1000000 + ((us > MicrosMax) ? MicrosMax : us);
    if (period_us < MinMicros) period_us = MinMicros;
    settings_used++;
  endtask

  function automatic void step_wall(longint unsigned delta_us);
    longint unsigned total;
    total     = longint'(wall_secs) * 1000000 + wall_us + delta_us;
    wall_secs = SecW'(total / 1000000);
    wall_us   = MicW'(total % 1000000);
  endfunction

  // one period with some jitter either side, exactly on time now and then
  function automatic longint unsigned near_period();
    longint unsigned span;
    longint          d;
    if ($urandom_range(4) == 0) return period_us;
    span = period_us / 4 + 3;
    if (span > 1000000) span = 1000000;
    d = longint'(period_us) + longint'($urandom_range(0, 32'(2 * span))) - longint'(span);
    return (d < 0) ? 0 : d;
  endfunction

  task automatic run_session(input int unsigned expiries);
    int unsigned roll;
    roll = $urandom_range(3);
    if (roll < 2) wall_secs = $urandom();
    else if (roll == 2) wall_secs = 32'hFFFF_FFFF - $urandom_range(0, 3);
    else wall_secs = $urandom_range(0, 1000);
    wall_us = $urandom_range(0, 999999);
    send_event(KIND_START, wall_secs, wall_us);
    repeat (expiries) begin
      roll = $urandom_range(99);
      if (roll < 80) begin
        step_wall(near_period());
        send_event(KIND_EXPIRY, wall_secs, wall_us);
      end else if (roll < 85) begin
        send_event(KIND_START, $urandom(), $urandom_range(0, 999999));
      end else if (roll < 90) begin
        send_event(KindUnused, $urandom(), $urandom());
      end else if (roll < 95) begin
        step_wall(near_period());
        send_event(KIND_EXPIRY, wall_secs, $urandom_range(1000000, 20'hFFFFF));
      end else begin
        step_wall(period_us * $urandom_range(2, 4) + $urandom_range(0, 999999));
        send_event(KIND_EXPIRY, wall_secs, wall_us);
      end
    end
    send_event(KIND_STOP, wall_secs, wall_us);
    if ($urandom_range(3) == 0) begin
      send_event(KIND_STOP, wall_secs, wall_us);
      step_wall(near_period());
      send_event(KIND_EXPIRY, wall_secs, wall_us);
    end
  endtask

  initial begin : stimulus
    logic [SecW-1:0] secs;
    logic [MicW-1:0] us;
    rst_ni         <= 1'b0;
    evt.valid      <= 1'b0;
    evt.kind       <= KIND_START;
    evt.now_secs   <= '0;
    evt.now_micros <= '0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CFG_INTERVAL_SECS;
    cfg_data_i     <= '0;
    period_us      = 20000;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: 20 ms period, no correction
    send_event(KIND_EXPIRY, '0, '0);
    send_event(KindUnused, 32'hFFFF_FFFF, 20'hFFFFF);
    send_event(KIND_STOP, 32'd3, 20'd3);
    send_event(KIND_START, 32'hFFFF_FFFF, 20'd990000);
    send_event(KIND_START, 32'd12, 20'd12);
    send_event(KIND_EXPIRY, 32'd0, 20'd10000);
    send_event(KIND_STOP, 32'd0, 20'd10000);

    // zero period floored to the minimum, correction on
    settle();
    write_settings('0, '0, 1'b1);
    send_event(KIND_START, 32'd100, 20'd0);
    send_event(KIND_EXPIRY, 32'd100, 20'd2);
    send_event(KIND_EXPIRY, 32'd100, 20'd3);
    send_event(KIND_EXPIRY, 32'd100, 20'd7);
    send_event(KIND_EXPIRY, 32'd101, 20'd0);
    send_event(KIND_EXPIRY, 32'd101, 20'hFFFFF);
    send_event(KIND_STOP, 32'd101, 20'd400);
    send_event(KIND_EXPIRY, 32'd101, 20'd500);

    // longest period, microseconds register above range
    settle();
    write_settings(32'hFFFF_FFFF, 20'hFFFFF, 1'b1);
    send_event(KIND_START, '0, '0);
    send_event(KIND_EXPIRY, 32'hFFFF_FFFF, 20'd999999);
    send_event(KIND_EXPIRY, 32'd5, 20'd0);
    send_event(KIND_STOP, 32'd5, 20'd0);

    settle();
    write_settings(32'd1, 20'd500000, 1'b0);
    send_event(KIND_START, 32'd7, 20'd0);
    send_event(KIND_EXPIRY, 32'd8, 20'd600000);
    send_event(KIND_STOP, 32'd9, 20'd0);

    for (int s = 0; s < Sessions; s++) begin
      settle();
      case ($urandom_range(9))
        0: begin secs = '0; us = '0; end
        1: begin secs = '0; us = 20'd1; end
        2: begin secs = '0; us = 20'd2; end
        3: begin secs = '0; us = ResetMicros; end
        4: begin secs = '0; us = MicrosMax; end
        5: begin secs = '0; us = $urandom_range(1000000, 20'hFFFFF); end
        6: begin secs = 32'd1; us = 20'd500000; end
        7: begin secs = $urandom_range(0, 3); us = $urandom_range(0, 999999); end
        8: begin secs = 32'hFFFF_FFFF; us = MicrosMax; end
        default: begin secs = $urandom(); us = $urandom(); end
      endcase
      write_settings(secs, us, $urandom_range(99) < 70);
      case (s % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 61; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 61; end
        default: begin gap_pct = 38; stall_pct = 38; end
      endcase
      run_session($urandom_range(12, 30));
    end

    evt.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
    $display("sent %0d start, %0d expiry, %0d stop and %0d unused-kind words over %0d settings",
             kinds_sent[0], kinds_sent[1], kinds_sent[2], kinds_sent[3], settings_used);
    $display("flow control free, with sender gaps, result stalls and both; %0d mismatches",
             fails);
    if (fails == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

### drift_corrected_periodic_timer_unit.f
rtl/core/dcpt_pkg.sv
rtl/core/dcpt_in_if.sv
rtl/core/dcpt_out_if.sv
rtl/core/dcpt_cfg_regs.sv
rtl/core/dcpt_step.sv
rtl/core/drift_corrected_periodic_timer_unit.sv
bench/timer_result_check.sv
bench/testbench.sv
